@@ rtl/core/lge_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lge_pkg
// shared types and constants of the life grid engine
// -----------------------------------------------------------------------------
`default_nettype none

package lge_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 64;

   localparam int COL_W = 6;
   localparam int ROW_W = 6;
   localparam int CNT_W = 7;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] REG_COLUMN_COUNT = 2'd0;
   localparam logic [1:0] REG_ROW_COUNT    = 2'd1;
   localparam logic [1:0] REG_WRAP_AROUND  = 2'd2;

   localparam logic [CNT_W-1:0] COLUMN_COUNT_RESET = CNT_W'(MAX_COLUMNS);
   localparam logic [CNT_W-1:0] ROW_COUNT_RESET    = CNT_W'(MAX_ROWS);

   typedef enum logic [1:0] {
      CMD_SET   = 2'd0,
      CMD_KILL  = 2'd1,
      CMD_NEXT  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      SEL_REQ,
      SEL_CUR,
      SEL_LAST,
      SEL_NEXT
   } row_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EDIT_WR,
      ST_GEN_CUR,
      ST_GEN_UP,
      ST_GEN_DN,
      ST_GEN_LAT,
      ST_GEN_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0] column_count;
      logic [CNT_W-1:0] row_count;
      logic             wrap_around;
   } cfg_type;

   typedef struct packed {
      logic        latch_req;
      logic        rd_en;
      row_sel_type rd_sel;
      logic        cap_cur;
      logic        cap_up;
      logic        cap_dn;
      logic        wr_edit;
      logic        wr_gen;
      logic        clear_all;
      logic        row_rst;
      logic        row_inc;
   } ctrl_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    last_row;
   } ctrl_status_type;

endpackage

`default_nettype wire

@@ rtl/core/life_grid_engine_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// life_grid_engine_core
// b3/s23 life grid with cell edit, clear and generation step requests
// -----------------------------------------------------------------------------
// usage
//   a request is taken when start is high and busy is low; it carries
//   req_command (set, kill, next generation, clear), req_column and req_row
//   busy stays high until the response, so one request is in flight at a time
//   the response is a one-cycle pulse on rsp_valid with rsp_cell_alive, the
//   state of the addressed cell afterwards (0 when it lies outside the area)
//   the receiver cannot stall: the pulse must be taken when it appears
//   latency from the accepting edge to the response cycle:
//     set / kill : 3 cycles (read-modify-write of one grid row)
//     clear      : 2 cycles (per-row valid flags dropped at once)
//     generation : 5 * rows + 2 cycles, 322 at 64 rows; each row costs three
//                  reads of the single-read-port row store, a capture and a
//                  write, all 64 columns of a row updated together
//   reset empties the grid (valid flags cleared) and loads column_count 64,
//   row_count 64, wrap_around 0; csr writes belong in idle periods only
// -----------------------------------------------------------------------------
`default_nettype none

module life_grid_engine_core (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // request channel
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [1:0]                  req_command,
   input  wire logic [lge_pkg::COL_W-1:0]   req_column,
   input  wire logic [lge_pkg::ROW_W-1:0]   req_row,
   // response channel
   output logic                             rsp_valid,
   output logic                             rsp_cell_alive,
   // configuration port
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [lge_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [lge_pkg::CSR_DW-1:0]  pwdata,
   output logic      [lge_pkg::CSR_DW-1:0]  prdata,
   output logic                             pready
);

   lge_pkg::cfg_type         cfg;
   lge_pkg::ctrl_cmd_type    ctrl_cmd;
   lge_pkg::ctrl_status_type ctrl_status;

   // register file
   lge_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencer: walks rows during a generation step
   lge_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (ctrl_status),
      .cmd       (ctrl_cmd)
   );

   // row store, neighbour window and update lanes
   lge_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_column     (req_column),
      .req_row        (req_row),
      .cfg            (cfg),
      .cmd            (ctrl_cmd),
      .status         (ctrl_status),
      .rsp_cell_alive (rsp_cell_alive)
   );

endmodule

`default_nettype wire

@@ rtl/core/lge_ram.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lge_ram
// generic simple dual-port ram with registered read
// -----------------------------------------------------------------------------
`default_nettype none

module lge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/lge_csr.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lge_csr
// configuration registers behind the apb-style port
// -----------------------------------------------------------------------------
`default_nettype none

module lge_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [lge_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [lge_pkg::CSR_DW-1:0]  pwdata,
   output logic      [lge_pkg::CSR_DW-1:0]  prdata,
   output logic                             pready,
   output lge_pkg::cfg_type                 cfg
);

   logic [lge_pkg::CNT_W-1:0] column_count_ff, column_count_in;
   logic [lge_pkg::CNT_W-1:0] row_count_ff, row_count_in;
   logic                      wrap_around_ff, wrap_around_in;
   logic                      wr_stb;
   logic [1:0]                reg_idx;

   assign pready  = 1'b1;
   assign wr_stb  = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      wrap_around_in  = wrap_around_ff;
      if (wr_stb) begin
         case (reg_idx)
            lge_pkg::REG_COLUMN_COUNT: column_count_in = pwdata[lge_pkg::CNT_W-1:0];
            lge_pkg::REG_ROW_COUNT:    row_count_in    = pwdata[lge_pkg::CNT_W-1:0];
            lge_pkg::REG_WRAP_AROUND:  wrap_around_in  = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= lge_pkg::COLUMN_COUNT_RESET;
         row_count_ff    <= lge_pkg::ROW_COUNT_RESET;
         wrap_around_ff  <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         wrap_around_ff  <= wrap_around_in;
      end
   end

   always_comb begin
      case (reg_idx)
         lge_pkg::REG_COLUMN_COUNT:
            prdata = lge_pkg::CSR_DW'(column_count_ff);
         lge_pkg::REG_ROW_COUNT:
            prdata = lge_pkg::CSR_DW'(row_count_ff);
         lge_pkg::REG_WRAP_AROUND:
            prdata = lge_pkg::CSR_DW'(wrap_around_ff);
         default:
            prdata = '0;
      endcase
   end

   assign cfg.column_count = column_count_ff;
   assign cfg.row_count    = row_count_ff;
   assign cfg.wrap_around  = wrap_around_ff;

endmodule

`default_nettype wire

@@ rtl/core/lge_ctrl.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lge_ctrl
// sequencer for edit, clear and generation requests
// -----------------------------------------------------------------------------
`default_nettype none

module lge_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   output logic                          rsp_valid,
   input  lge_pkg::ctrl_status_type      status,
   output lge_pkg::ctrl_cmd_type         cmd
);

   lge_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lge_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.rd_sel = lge_pkg::SEL_REQ;
      busy      = (state_ff != lge_pkg::ST_IDLE);
      rsp_valid = 1'b0;
      case (state_ff)
         lge_pkg::ST_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = lge_pkg::ST_DISPATCH;
            end
         end
         lge_pkg::ST_DISPATCH: begin
            case (status.cmd)
               lge_pkg::CMD_SET, lge_pkg::CMD_KILL: begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = lge_pkg::SEL_REQ;
                  state_in   = lge_pkg::ST_EDIT_WR;
               end
               lge_pkg::CMD_NEXT: begin
                  cmd.row_rst = 1'b1;
                  state_in    = lge_pkg::ST_GEN_CUR;
               end
               default: begin
                  cmd.clear_all = 1'b1;
                  state_in      = lge_pkg::ST_DONE;
               end
            endcase
         end
         lge_pkg::ST_EDIT_WR: begin
            cmd.wr_edit = 1'b1;
            state_in    = lge_pkg::ST_DONE;
         end
         lge_pkg::ST_GEN_CUR: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lge_pkg::SEL_CUR;
            state_in   = lge_pkg::ST_GEN_UP;
         end
         lge_pkg::ST_GEN_UP: begin
            cmd.cap_cur = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_sel  = lge_pkg::SEL_LAST;
            state_in    = lge_pkg::ST_GEN_DN;
         end
         lge_pkg::ST_GEN_DN: begin
            cmd.cap_up = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = lge_pkg::SEL_NEXT;
            state_in   = lge_pkg::ST_GEN_LAT;
         end
         lge_pkg::ST_GEN_LAT: begin
            cmd.cap_dn = 1'b1;
            state_in   = lge_pkg::ST_GEN_WR;
         end
         lge_pkg::ST_GEN_WR: begin
            cmd.wr_gen = 1'b1;
            if (status.last_row) begin
               state_in = lge_pkg::ST_DONE;
            end else begin
               cmd.row_inc = 1'b1;
               state_in    = lge_pkg::ST_GEN_CUR;
            end
         end
         lge_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = lge_pkg::ST_IDLE;
         end
         default: begin
            state_in = lge_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/core/lge_dpath.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lge_dpath
// row store, three-row window and 64-lane b3/s23 update
// -----------------------------------------------------------------------------
`default_nettype none

module lge_dpath (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [1:0]                  req_command,
   input  wire logic [lge_pkg::COL_W-1:0]   req_column,
   input  wire logic [lge_pkg::ROW_W-1:0]   req_row,
   input  lge_pkg::cfg_type                 cfg,
   input  lge_pkg::ctrl_cmd_type            cmd,
   output lge_pkg::ctrl_status_type         status,
   output logic                             rsp_cell_alive
);

   localparam int W = lge_pkg::MAX_COLUMNS;
   localparam int D = lge_pkg::MAX_ROWS;

   lge_pkg::cmd_type          cmd_ff;
   logic [lge_pkg::COL_W-1:0] col_ff;
   logic [lge_pkg::ROW_W-1:0] reqrow_ff;
   logic [lge_pkg::CNT_W-1:0] cols_ff, rows_ff, cols_in, rows_in;
   logic                      wrap_ff;
   logic [lge_pkg::ROW_W-1:0] row_ff;
   logic                      result_ff;
   logic [D-1:0]              valid_ff;
   logic                      rd_valid_ff;
   logic [W-1:0]              cur_ff, up_ff, dn_ff, prev_ff, row0_ff;

   logic [lge_pkg::ROW_W-1:0] rd_addr;
   logic [W-1:0]              ram_q, rd_row, edit_row, next_row, wr_data;
   logic                      wr_en, in_area;
   logic [lge_pkg::COL_W-1:0] lastc;

   // clamp counts to 1..max
   always_comb begin
      cols_in = cfg.column_count;
      rows_in = cfg.row_count;
      if (cfg.column_count == '0) cols_in = lge_pkg::CNT_W'(1);
      else if (cfg.column_count > lge_pkg::CNT_W'(W)) cols_in = lge_pkg::CNT_W'(W);
      if (cfg.row_count == '0) rows_in = lge_pkg::CNT_W'(1);
      else if (cfg.row_count > lge_pkg::CNT_W'(D)) rows_in = lge_pkg::CNT_W'(D);
   end

   assign in_area = ({1'b0, col_ff} < cols_ff) && ({1'b0, reqrow_ff} < rows_ff);
   assign status.cmd      = cmd_ff;
   assign status.last_row = (lge_pkg::CNT_W'(row_ff) + lge_pkg::CNT_W'(1)) >= rows_ff;

   always_comb begin
      case (cmd.rd_sel)
         lge_pkg::SEL_REQ:  rd_addr = reqrow_ff;
         lge_pkg::SEL_CUR:  rd_addr = row_ff;
         lge_pkg::SEL_LAST: rd_addr = lge_pkg::ROW_W'(rows_ff - lge_pkg::CNT_W'(1));
         default:           rd_addr = row_ff + lge_pkg::ROW_W'(1);
      endcase
   end

   lge_ram #(.WIDTH(W), .DEPTH(D)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cmd.wr_gen ? row_ff : reqrow_ff),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // rows never written since the last clear read as dead
   assign rd_row = rd_valid_ff ? ram_q : '0;

   always_comb begin
      edit_row          = rd_row;
      edit_row[col_ff]  = (cmd_ff == lge_pkg::CMD_SET);
   end

   assign lastc = lge_pkg::COL_W'(cols_ff - lge_pkg::CNT_W'(1));

   // one lane per column
   always_comb begin
      logic [2:0] lb, rb, mb;
      logic [3:0] n;
      logic       edge_l, edge_r;
      for (int c = 0; c < W; c++) begin
         edge_l = (c == 0);
         edge_r = (lge_pkg::CNT_W'(c) + lge_pkg::CNT_W'(1)) >= cols_ff;
         mb = {up_ff[c], cur_ff[c], dn_ff[c]};
         if (edge_l) begin
            lb = wrap_ff ? {up_ff[lastc], cur_ff[lastc], dn_ff[lastc]} : 3'b000;
         end else begin
            lb = {up_ff[(c+W-1)%W], cur_ff[(c+W-1)%W], dn_ff[(c+W-1)%W]};
         end
         if (edge_r) begin
            rb = wrap_ff ? {up_ff[0], cur_ff[0], dn_ff[0]} : 3'b000;
         end else begin
            rb = {up_ff[(c+1)%W], cur_ff[(c+1)%W], dn_ff[(c+1)%W]};
         end
         n = 4'(lb[2]) + 4'(lb[1]) + 4'(lb[0]) + 4'(rb[2]) + 4'(rb[1]) + 4'(rb[0])
           + 4'(mb[2]) + 4'(mb[0]);
         if (lge_pkg::CNT_W'(c) < cols_ff) begin
            next_row[c] = (n == 4'd3) || (cur_ff[c] && (n == 4'd2));
         end else begin
            next_row[c] = cur_ff[c];
         end
      end
   end

   assign wr_en   = cmd.wr_gen | (cmd.wr_edit & in_area);
   assign wr_data = cmd.wr_gen ? next_row : edit_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.clear_all) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[cmd.wr_gen ? row_ff : reqrow_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
      if (cmd.latch_req) begin
         cmd_ff    <= lge_pkg::cmd_type'(req_command);
         col_ff    <= req_column;
         reqrow_ff <= req_row;
         cols_ff   <= cols_in;
         rows_ff   <= rows_in;
         wrap_ff   <= cfg.wrap_around;
      end
      if (cmd.row_rst) begin
         row_ff <= '0;
      end else if (cmd.row_inc) begin
         row_ff <= row_ff + lge_pkg::ROW_W'(1);
      end
      if (cmd.cap_cur) begin
         cur_ff <= rd_row;
         if (row_ff == '0) begin
            row0_ff <= rd_row;
         end
      end
      if (cmd.cap_up) begin
         if (row_ff == '0) begin
            up_ff <= wrap_ff ? rd_row : '0;
         end else begin
            up_ff <= prev_ff;
         end
      end
      if (cmd.cap_dn) begin
         if (status.last_row) begin
            dn_ff <= wrap_ff ? row0_ff : '0;
         end else begin
            dn_ff <= rd_row;
         end
      end
      if (cmd.wr_gen) begin
         prev_ff <= cur_ff;
      end
      if (cmd.clear_all || cmd.row_rst) begin
         result_ff <= 1'b0;
      end else if (cmd.wr_edit) begin
         result_ff <= in_area && (cmd_ff == lge_pkg::CMD_SET);
      end else if (cmd.wr_gen && in_area && (row_ff == reqrow_ff)) begin
         result_ff <= next_row[col_ff];
      end
   end

   assign rsp_cell_alive = result_ff;

endmodule

`default_nettype wire

@@ rtl/core/lge_checker.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// lge_checker
// port-level checks of request and response sequencing
// -----------------------------------------------------------------------------
`default_nettype none

module lge_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid
);

   // an accepted request holds the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but busy not raised");

   // response only while a request is in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response without request in flight");

   // response is a single-cycle pulse
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response held longer than one cycle");

   // busy drops only right after the response
   a_busy_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid))
      else $error("busy dropped without response");

   // idle straight out of reset
   a_reset_idle: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> !busy)
      else $error("busy after reset");

endmodule

bind life_grid_engine_core lge_checker u_lge_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);

`default_nettype wire

@@ test/tb_life_grid_engine_core.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_life_grid_engine_core
// self-checking bench for the b3/s23 life grid engine
// -----------------------------------------------------------------------------
// a shadow grid predicts the cell state returned by every request; requests
// come from a queue filled by the stimulus block and are driven with random
// gaps, responses are checked in order as they pulse out. csr writes happen
// only with the engine idle, across several grid sizes and both edge modes
// -----------------------------------------------------------------------------
`default_nettype none

module tb_life_grid_engine_core;

   typedef struct packed {
      lge_pkg::cmd_type          command;
      logic [lge_pkg::COL_W-1:0] column;
      logic [lge_pkg::ROW_W-1:0] row;
   } life_req_type;

   localparam int STALL_LIMIT = 20000;
   localparam int SIZES_C[6] = '{4, 1, 2, 64, 0, 100};
   localparam int SIZES_R[6] = '{5, 3, 2, 64, 127, 0};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                         start = 1'b0;
   logic                         busy;
   logic [1:0]                   req_command = '0;
   logic [lge_pkg::COL_W-1:0]    req_column = '0;
   logic [lge_pkg::ROW_W-1:0]    req_row = '0;
   logic                         rsp_valid;
   logic                         rsp_cell_alive;
   logic                         psel = 1'b0;
   logic                         penable = 1'b0;
   logic                         pwrite = 1'b0;
   logic [lge_pkg::CSR_AW-1:0]   paddr = '0;
   logic [lge_pkg::CSR_DW-1:0]   pwdata = '0;
   logic [lge_pkg::CSR_DW-1:0]   prdata;
   logic                         pready;

   life_grid_engine_core dut (
      .clock(clock), .reset(reset),
      .start(start), .busy(busy),
      .req_command(req_command), .req_column(req_column), .req_row(req_row),
      .rsp_valid(rsp_valid), .rsp_cell_alive(rsp_cell_alive),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // shadow of the grid and registers
   logic                      grid [lge_pkg::MAX_ROWS][lge_pkg::MAX_COLUMNS];
   logic [lge_pkg::CNT_W-1:0] col_reg = lge_pkg::COLUMN_COUNT_RESET;
   logic [lge_pkg::CNT_W-1:0] row_reg = lge_pkg::ROW_COUNT_RESET;
   logic                      wrap_reg = 1'b0;

   life_req_type pending_reqs[$];
   logic         expected_alive[$];
   int           gap = 0;
   int           idle_cycles = 0;
   int           errors = 0;
   logic         accepted_last = 1'b0;

   function automatic int active_size(logic [lge_pkg::CNT_W-1:0] v, int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : int'(v);
   endfunction

   // apply one request to the shadow grid and return the addressed cell
   function automatic logic life_apply(life_req_type rq);
      int  cols, rows, n, nc, nr;
      bit  in_area, skip;
      logic prev [lge_pkg::MAX_ROWS][lge_pkg::MAX_COLUMNS];
      cols = active_size(col_reg, lge_pkg::MAX_COLUMNS);
      rows = active_size(row_reg, lge_pkg::MAX_ROWS);
      in_area = (rq.column < cols) && (rq.row < rows);
      case (rq.command)
         lge_pkg::CMD_SET:  if (in_area) grid[rq.row][rq.column] = 1'b1;
         lge_pkg::CMD_KILL: if (in_area) grid[rq.row][rq.column] = 1'b0;
         lge_pkg::CMD_NEXT: begin
            prev = grid;
            for (int r = 0; r < rows; r++)
               for (int c = 0; c < cols; c++) begin
                  n = 0;
                  for (int dr = -1; dr <= 1; dr++)
                     for (int dc = -1; dc <= 1; dc++) begin
                        skip = (dr == 0 && dc == 0);
                        nc = c + dc;
                        nr = r + dr;
                        // past an edge: opposite side with wrap, else dead
                        if (nc < 0 || nc >= cols) begin
                           if (!wrap_reg) skip = 1;
                           nc = (nc < 0) ? cols - 1 : 0;
                        end
                        if (nr < 0 || nr >= rows) begin
                           if (!wrap_reg) skip = 1;
                           nr = (nr < 0) ? rows - 1 : 0;
                        end
                        if (!skip) n += prev[nr][nc];
                     end
                  grid[r][c] = prev[r][c] ? (n == 2 || n == 3) : (n == 3);
               end
         end
         default: begin
            for (int r = 0; r < lge_pkg::MAX_ROWS; r++)
               for (int c = 0; c < lge_pkg::MAX_COLUMNS; c++) grid[r][c] = 1'b0;
         end
      endcase
      return in_area ? grid[rq.row][rq.column] : 1'b0;
   endfunction

   // request driver: random gap before each request, held until accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (start && accepted_last) begin
            start <= 1'b0;
            gap   <= $urandom_range(0, 10);
         end else if (!start && pending_reqs.size() > 0) begin
            if (gap > 0) gap <= gap - 1;
            else begin
               life_req_type rq;
               rq = pending_reqs.pop_front();
               req_command <= rq.command;
               req_column  <= rq.column;
               req_row     <= rq.row;
               start       <= 1'b1;
               expected_alive.push_back(life_apply(rq));
            end
         end
      end
   end

   // acceptance seen at the rising edge
   always @(posedge clock) begin
      accepted_last <= start && !busy && !reset;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_alive.size() == 0) begin
            $error("unexpected response cell_alive=%0b", rsp_cell_alive);
            errors <= errors + 1;
         end else begin
            logic exp_bit;
            exp_bit = expected_alive.pop_front();
            if (rsp_cell_alive !== exp_bit) begin
               $error("cell_alive expected %0b actual %0b", exp_bit, rsp_cell_alive);
               errors <= errors + 1;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   task automatic csr_write(logic [1:0] index, logic [lge_pkg::CSR_DW-1:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= lge_pkg::CSR_AW'({index, 2'b00});
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (index)
         lge_pkg::REG_COLUMN_COUNT: col_reg = value[lge_pkg::CNT_W-1:0];
         lge_pkg::REG_ROW_COUNT:    row_reg = value[lge_pkg::CNT_W-1:0];
         default:                   wrap_reg = value[0];
      endcase
   endtask

   task automatic wait_drained();
      wait (pending_reqs.size() == 0 && expected_alive.size() == 0 && !start);
      repeat (4) @(negedge clock);
   endtask

   function automatic life_req_type any_req(int cols, int rows, int next_weight);
      life_req_type rq;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < next_weight) rq.command = lge_pkg::CMD_NEXT;
      else if (pick < next_weight + 2) rq.command = lge_pkg::CMD_CLEAR;
      else if (pick < 75) rq.command = lge_pkg::CMD_SET;
      else rq.command = lge_pkg::CMD_KILL;
      // mostly inside the area, sometimes anywhere
      if ($urandom_range(0, 9) == 0) begin
         rq.column = lge_pkg::COL_W'($urandom);
         rq.row    = lge_pkg::ROW_W'($urandom);
      end else begin
         rq.column = lge_pkg::COL_W'($urandom_range(0, cols - 1));
         rq.row    = lge_pkg::ROW_W'($urandom_range(0, rows - 1));
      end
      return rq;
   endfunction

   task automatic push(lge_pkg::cmd_type c, int col, int row);
      life_req_type rq;
      rq.command = c;
      rq.column  = lge_pkg::COL_W'(col);
      rq.row     = lge_pkg::ROW_W'(row);
      pending_reqs.push_back(rq);
   endtask

   initial begin
      int cc, rr;
      for (int r = 0; r < lge_pkg::MAX_ROWS; r++)
         for (int c = 0; c < lge_pkg::MAX_COLUMNS; c++) grid[r][c] = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: default 64x64 grid, corners, glider, blinker at the edge
      push(lge_pkg::CMD_NEXT, 0, 0);
      push(lge_pkg::CMD_SET, 63, 63);
      push(lge_pkg::CMD_SET, 0, 0);
      push(lge_pkg::CMD_KILL, 0, 0);
      push(lge_pkg::CMD_SET, 1, 0); push(lge_pkg::CMD_SET, 2, 1);
      push(lge_pkg::CMD_SET, 0, 2);
      push(lge_pkg::CMD_SET, 1, 2); push(lge_pkg::CMD_SET, 2, 2);
      push(lge_pkg::CMD_NEXT, 1, 2);
      push(lge_pkg::CMD_NEXT, 2, 3);
      push(lge_pkg::CMD_SET, 63, 10); push(lge_pkg::CMD_SET, 63, 11);
      push(lge_pkg::CMD_SET, 63, 12);
      push(lge_pkg::CMD_NEXT, 63, 11);
      push(lge_pkg::CMD_CLEAR, 63, 63);
      wait_drained();

      // outside the area, and both edge modes with grid sizes from tiny to full
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(lge_pkg::REG_COLUMN_COUNT, SIZES_C[ph]);
         csr_write(lge_pkg::REG_ROW_COUNT, SIZES_R[ph]);
         csr_write(lge_pkg::REG_WRAP_AROUND, ph % 2);
         cc = active_size(col_reg, lge_pkg::MAX_COLUMNS);
         rr = active_size(row_reg, lge_pkg::MAX_ROWS);
         push(lge_pkg::CMD_SET, 63, 63);
         push(lge_pkg::CMD_SET, cc - 1, rr - 1);
         push(lge_pkg::CMD_CLEAR, 0, 0);
         // random part, several seeds of activity per step
         for (int i = 0; i < (ph == 3 ? 10 : 18); i++)
            pending_reqs.push_back(any_req(cc, rr, (cc * rr > 64) ? 6 : 18));
         wait_drained();
      end
      csr_write(lge_pkg::REG_WRAP_AROUND, 32'hFFFF_FFFE);
      csr_write(lge_pkg::REG_COLUMN_COUNT, 32'hFFFF_FF83);
      csr_write(lge_pkg::REG_ROW_COUNT, 32'h0000_0003);
      for (int i = 0; i < 10; i++) pending_reqs.push_back(any_req(3, 3, 30));
      wait_drained();
      repeat (400) @(negedge clock);

      if (errors == 0 && expected_alive.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
